>>> hw/rtl/amh_pkg.sv
// Shared types and constants for the addressable max-heap.
// No dependencies; the controller, datapath and top import this package.
`timescale 1ns / 1ps
`default_nettype none
package amh_pkg;

	localparam int NUM_IDS  = 256;
	localparam int ID_W     = 8;
	localparam int KEY_BITS = 32;
	localparam int CNT_W    = 9;
	localparam int PM_W     = 9;

	localparam logic [2:0] ACT_PUSH   = 3'd0;
	localparam logic [2:0] ACT_MODIFY = 3'd1;
	localparam logic [2:0] ACT_DELETE = 3'd2;
	localparam logic [2:0] ACT_DEACT  = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_NOT_IN  = 3'd3;
	localparam logic [2:0] ST_PRESENT = 3'd4;

	// position map codes below the slot offset
	localparam logic [PM_W-1:0] PM_ABSENT = 9'd0;
	localparam logic [PM_W-1:0] PM_DEACT  = 9'd1;
	localparam logic [PM_W-1:0] PM_SLOT0  = 9'd2;

	typedef struct packed {
		logic [2:0]                 action;
		logic [ID_W-1:0]            entity_id;
		logic signed [KEY_BITS-1:0] key_value;
	} in_word_t;

	typedef struct packed {
		logic [2:0]                 status;
		logic signed [KEY_BITS-1:0] top_key;
		logic [ID_W-1:0]            top_id;
		logic [CNT_W-1:0]           heap_count;
		logic signed [KEY_BITS-1:0] removed_key;
		logic [ID_W-1:0]            removed_id;
		logic                       probe_present;
		logic                       probe_active;
		logic signed [KEY_BITS-1:0] probe_key;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_DECIDE, S_GONE, S_SK_RD, S_SK_CMP,
		S_UP_RD, S_UP_CMP, S_PLACE, S_FIN1, S_FIN2, S_FIN3, S_REUP
	} state_t;

	typedef struct packed {
		logic capture;
		logic look;
		logic decide;
		logic gone;
		logic sk_rd;
		logic sk_cmp;
		logic up_rd;
		logic up_cmp;
		logic place;
		logic reup;
		logic fin1;
		logic fin2;
		logic fin3;
	} cmd_t;

	typedef struct packed {
		logic go_up;
		logic go_sink;
		logic go_gone;
		logic gone_last;
		logic sk_end;
		logic sk_swap;
		logic sk_moved;
		logic then_up;
		logic p_zero;
		logic up_swap;
		logic out_busy;
	} stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/amh_stream_if.sv
// Valid/ready channel carrying one word of type T.
// Depends on nothing; payload types come from amh_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface amh_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/amh_ctrl.sv
// Sequencer for the heap: steps push, modify, pop (delete or deactivate), clear and result reads.
// Depends on amh_pkg; drives the datapath through cmd_t, reads stat_t.
`timescale 1ns / 1ps
`default_nettype none
module amh_ctrl import amh_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t st,
	output cmd_t       cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_LOOK;
			S_LOOK:   state_d = S_DECIDE;
			S_DECIDE: begin
				if (st.go_up) state_d = S_UP_RD;
				else if (st.go_sink) state_d = S_SK_RD;
				else if (st.go_gone) state_d = S_GONE;
				else state_d = S_FIN1;
			end
			S_GONE:   state_d = st.gone_last ? S_FIN1 : S_SK_RD;
			S_SK_RD: begin
				if (!st.sk_end) state_d = S_SK_CMP;
				else if (!st.then_up) state_d = S_PLACE;
				else state_d = st.sk_moved ? S_REUP : S_UP_RD;
			end
			S_SK_CMP: begin
				if (st.sk_swap) state_d = S_SK_RD;
				else if (!st.then_up) state_d = S_PLACE;
				else state_d = st.sk_moved ? S_REUP : S_UP_RD;
			end
			// sift up again from the modified slot with the child promoted into it
			S_REUP:   state_d = S_UP_RD;
			S_UP_RD:  state_d = st.p_zero ? S_PLACE : S_UP_CMP;
			S_UP_CMP: state_d = st.up_swap ? S_UP_RD : S_PLACE;
			S_PLACE:  state_d = S_FIN1;
			S_FIN1:   state_d = S_FIN2;
			S_FIN2:   state_d = S_FIN3;
			S_FIN3:   if (!st.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_LOOK:   cmd.look   = 1'b1;
			S_DECIDE: cmd.decide = 1'b1;
			S_GONE:   cmd.gone   = 1'b1;
			S_SK_RD:  cmd.sk_rd  = 1'b1;
			S_SK_CMP: cmd.sk_cmp = 1'b1;
			S_REUP:   cmd.reup   = 1'b1;
			S_UP_RD:  cmd.up_rd  = 1'b1;
			S_UP_CMP: cmd.up_cmp = 1'b1;
			S_PLACE:  cmd.place  = 1'b1;
			S_FIN1:   cmd.fin1   = 1'b1;
			S_FIN2:   cmd.fin2   = 1'b1;
			S_FIN3:   cmd.fin3   = 1'b1;
			default:  cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

>>> hw/rtl/amh_dp.sv
// Heap datapath: slot key/id memories, position map with valid bits,
// carried node, walk position and result register. Depends on amh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module amh_dp import amh_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cmd_t     cmd,
	input  wire in_word_t in_data,
	output stat_t         st,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_word_t     out_data
);
	localparam int SLOT_W = $clog2(NUM_IDS);

	logic signed [KEY_BITS-1:0] key_mem [NUM_IDS];
	logic [ID_W-1:0]            id_mem  [NUM_IDS];
	logic [PM_W-1:0]            pm_mem  [NUM_IDS];
	logic [NUM_IDS-1:0]         pm_vld_q;

	logic [2:0]                 act_q;
	logic [ID_W-1:0]            id_q;
	logic signed [KEY_BITS-1:0] kin_q;
	logic [CNT_W-1:0]           count_q;
	logic [SLOT_W-1:0]          p_q;
	logic signed [KEY_BITS-1:0] ck_q;
	logic [ID_W-1:0]            cid_q;
	logic signed [KEY_BITS-1:0] rem_key_q;
	logic [ID_W-1:0]            rem_id_q;
	logic [2:0]                 stat_q;
	logic                       then_up_q;
	logic                       out_valid_q;
	logic [SLOT_W-1:0]          s0_q;
	logic signed [KEY_BITS-1:0] uk_q;
	logic [ID_W-1:0]            uid_q;
	logic                       moved_q;
	logic [2:0]                 dec_stat;

	logic signed [KEY_BITS-1:0] rka_q, rkb_q;
	logic [ID_W-1:0]            ria_q, rib_q;
	logic [PM_W-1:0]            rpm_q;
	logic                       rvld_q;

	// read ports
	logic              a_en, b_en, pm_en;
	logic [SLOT_W-1:0] a_addr, b_addr;
	logic [ID_W-1:0]   pm_raddr;
	// write ports
	logic                       w_en, pmw_en;
	logic [SLOT_W-1:0]          w_addr;
	logic signed [KEY_BITS-1:0] w_key;
	logic [ID_W-1:0]            w_id, pmw_addr;
	logic [PM_W-1:0]            pmw_data;

	logic [CNT_W-1:0]  l_idx;
	logic [CNT_W:0]    r_idx;
	logic              r_ok, pick_r, pm_hit;
	logic [PM_W-1:0]   pm_slot;
	logic signed [KEY_BITS-1:0] kc;
	logic [ID_W-1:0]   ic;
	logic [SLOT_W-1:0] c_idx, par_idx;
	logic [PM_W-1:0]   p_code;

	assign l_idx   = {p_q, 1'b1};
	assign r_idx   = {1'b0, l_idx} + 10'd1;
	assign r_ok    = r_idx < {1'b0, count_q};
	assign pick_r  = r_ok && (rka_q < rkb_q);
	assign kc      = pick_r ? rkb_q : rka_q;
	assign ic      = pick_r ? rib_q : ria_q;
	assign c_idx   = pick_r ? r_idx[SLOT_W-1:0] : l_idx[SLOT_W-1:0];
	assign par_idx = (p_q - SLOT_W'(1)) >> 1;
	assign p_code  = {1'b0, p_q} + PM_SLOT0;
	assign pm_hit  = rvld_q && (rpm_q >= PM_SLOT0);
	assign pm_slot = rpm_q - PM_SLOT0;

	always_comb begin
		st = '0;
		unique case (act_q)
			ACT_PUSH:   st.go_up = !count_q[CNT_W-1] && !pm_hit;
			ACT_MODIFY: st.go_sink = pm_hit && (pm_slot < count_q);
			ACT_DELETE, ACT_DEACT: st.go_gone = count_q != '0;
			default: st.go_up = 1'b0;
		endcase
		st.gone_last = count_q == '0;
		st.sk_end    = l_idx >= count_q;
		st.sk_swap   = ck_q < kc;
		st.sk_moved  = moved_q;
		st.then_up   = then_up_q;
		st.p_zero    = p_q == '0;
		st.up_swap   = !(ck_q < rka_q);
		st.out_busy  = out_valid_q && !out_ready;
	end

	always_comb begin
		dec_stat = ST_OK;
		unique case (act_q)
			ACT_PUSH: begin
				if (count_q[CNT_W-1]) dec_stat = ST_FULL;
				else if (pm_hit) dec_stat = ST_PRESENT;
			end
			ACT_MODIFY: if (!st.go_sink) dec_stat = ST_NOT_IN;
			ACT_DELETE, ACT_DEACT: if (!st.go_gone) dec_stat = ST_EMPTY;
			default: dec_stat = ST_OK;
		endcase
	end

	always_comb begin
		a_en     = cmd.look | cmd.sk_rd | cmd.up_rd | cmd.fin1;
		b_en     = cmd.look | cmd.sk_rd | cmd.fin2;
		pm_en    = cmd.look | cmd.fin1;
		pm_raddr = id_q;
		a_addr   = '0;
		b_addr   = pm_slot[SLOT_W-1:0];
		if (cmd.look) b_addr = SLOT_W'(count_q - 9'd1);
		if (cmd.sk_rd) begin
			a_addr = l_idx[SLOT_W-1:0];
			b_addr = r_idx[SLOT_W-1:0];
		end
		if (cmd.up_rd) a_addr = par_idx;
	end

	always_comb begin
		w_en     = 1'b0;
		w_addr   = p_q;
		w_key    = ck_q;
		w_id     = cid_q;
		pmw_en   = 1'b0;
		pmw_addr = cid_q;
		pmw_data = p_code;
		if (cmd.sk_cmp && st.sk_swap) begin
			w_en = 1'b1; w_key = kc; w_id = ic;
			pmw_en = 1'b1; pmw_addr = ic;
		end
		if (cmd.up_cmp && st.up_swap) begin
			w_en = 1'b1; w_key = rka_q; w_id = ria_q;
			pmw_en = 1'b1; pmw_addr = ria_q;
		end
		if (cmd.place || cmd.reup) begin
			w_en = 1'b1; pmw_en = 1'b1;
		end
		if (cmd.gone) begin
			pmw_en   = 1'b1;
			pmw_addr = rem_id_q;
			pmw_data = (act_q == ACT_DEACT) ? PM_DEACT : PM_ABSENT;
		end
	end

	always_ff @(posedge clk) begin
		if (w_en) begin
			key_mem[w_addr] <= w_key;
			id_mem[w_addr]  <= w_id;
		end
		if (pmw_en) pm_mem[pmw_addr] <= pmw_data;
		if (a_en) begin
			rka_q <= key_mem[a_addr];
			ria_q <= id_mem[a_addr];
		end
		if (b_en) begin
			rkb_q <= key_mem[b_addr];
			rib_q <= id_mem[b_addr];
		end
		if (pm_en) rpm_q <= pm_mem[pm_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_vld_q <= '0;
			rvld_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			if (pm_en) rvld_q <= pm_vld_q[pm_raddr];
			if (pmw_en) pm_vld_q[pmw_addr] <= 1'b1;
			if (cmd.decide) begin
				unique case (act_q)
					ACT_PUSH: if (st.go_up) count_q <= count_q + 9'd1;
					ACT_DELETE, ACT_DEACT: if (st.go_gone) count_q <= count_q - 9'd1;
					ACT_CLEAR: begin
						count_q  <= '0;
						pm_vld_q <= '0;
					end
					default: count_q <= count_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= in_data.action;
			id_q  <= in_data.entity_id;
			kin_q <= in_data.key_value;
		end
		if (cmd.decide) begin
			stat_q    <= dec_stat;
			rem_key_q <= st.go_gone ? rka_q : '0;
			rem_id_q  <= st.go_gone ? ria_q : '0;
			then_up_q <= act_q == ACT_MODIFY;
			unique case (act_q)
				ACT_PUSH: begin
					p_q   <= count_q[SLOT_W-1:0];
					ck_q  <= kin_q;
					cid_q <= id_q;
				end
				ACT_MODIFY: begin
					p_q   <= pm_slot[SLOT_W-1:0];
					s0_q  <= pm_slot[SLOT_W-1:0];
					ck_q  <= kin_q;
					cid_q <= id_q;
				end
				ACT_DELETE, ACT_DEACT: begin
					p_q   <= '0;
					ck_q  <= rkb_q;
					cid_q <= rib_q;
				end
				default: p_q <= p_q;
			endcase
		end
		if (cmd.decide) moved_q <= 1'b0;
		else if (cmd.sk_cmp && st.sk_swap) moved_q <= 1'b1;
		// hold the child promoted into the start slot by the first sink step
		if (cmd.sk_cmp && st.sk_swap && !moved_q) begin
			uk_q  <= kc;
			uid_q <= ic;
		end
		if (cmd.sk_cmp && st.sk_swap) p_q <= c_idx;
		if (cmd.up_cmp && st.up_swap) p_q <= par_idx;
		if (cmd.reup) begin
			p_q   <= s0_q;
			ck_q  <= uk_q;
			cid_q <= uid_q;
		end
		if (cmd.fin3 && !st.out_busy) begin
			out_data.status        <= stat_q;
			out_data.top_key       <= (count_q != '0) ? rka_q : '0;
			out_data.top_id        <= (count_q != '0) ? ria_q : '0;
			out_data.heap_count    <= count_q;
			out_data.removed_key   <= rem_key_q;
			out_data.removed_id    <= rem_id_q;
			out_data.probe_present <= rvld_q && (rpm_q != PM_ABSENT);
			out_data.probe_active  <= pm_hit;
			out_data.probe_key     <= pm_hit ? rkb_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.fin3 && !st.out_busy) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

>>> hw/rtl/addressable_max_heap_top.sv
// Addressable max-heap of (key, id) pairs with a per-id position map.
// Each accepted word is handled alone and yields one result word. An item steps
// through accept, lookup, decide, a map update for a removed id, the walk over
// the single-write slot memories (per tree level moved a registered memory read
// and a compare and swap, each walk ending at a read or at a compare that does
// not swap, then a write of the carried node back, and for a modify that sank a
// restart of the sift-up at its slot) and three result reads. It holds in its
// last state until the previous result word is taken.
// Clear is immediate through per-id valid bits; no clearing pass.
// Depends on amh_pkg, amh_stream_if, amh_ctrl and amh_dp.
`timescale 1ns / 1ps
`default_nettype none
module addressable_max_heap_top import amh_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	amh_stream_if.sink   req,
	amh_stream_if.source rsp
);
	cmd_t  cmd;
	stat_t st;

	amh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	amh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (req.data),
		.st        (st),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (rsp.data)
	);
endmodule
`default_nettype wire
